>>> sv/chd_pkg.sv
// Shared codes for the chunked body decoder: parse phases, result status and byte values.
`default_nettype none
package chd_pkg;

  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned STATUS_W = 3;

  localparam logic [PHASE_W-1:0] PH_SIZE         = 3'd0;
  localparam logic [PHASE_W-1:0] PH_EXT          = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DATA         = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DATA_END     = 3'd3;
  localparam logic [PHASE_W-1:0] PH_TRAILER      = 3'd4;
  localparam logic [PHASE_W-1:0] PH_TRAILER_LINE = 3'd5;

  localparam logic [STATUS_W-1:0] ST_FRAME   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PAYLOAD = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ERROR   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd4;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] b);
    hex_digit_t h;
    h.is_hex = 1'b0;
    h.value  = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.is_hex = 1'b1;
      h.value  = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.is_hex = 1'b1;
      h.value  = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.is_hex = 1'b1;
      h.value  = 4'(b - 8'h37);
    end
    return h;
  endfunction

endpackage
`default_nettype wire

>>> sv/chd_step.sv
// Per-byte framing update: next parse state and the result for one byte.
`default_nettype none
module chd_step #(
  parameter int unsigned COUNT_WIDTH = 64
) (
  input  wire logic [7:0]                     byte_i,
  input  wire logic                           sob_i,
  input  wire logic [chd_pkg::PHASE_W-1:0]    phase_i,
  input  wire logic [COUNT_WIDTH-1:0]         chunk_i,
  input  wire logic                           done_i,
  input  wire logic                           err_i,
  output logic      [chd_pkg::PHASE_W-1:0]    phase_o,
  output logic      [COUNT_WIDTH-1:0]         chunk_o,
  output logic                                done_o,
  output logic                                err_o,
  output logic      [7:0]                     out_byte_o,
  output logic      [chd_pkg::STATUS_W-1:0]   status_o
);

  logic [chd_pkg::PHASE_W-1:0] phase_cur;
  logic [chd_pkg::PHASE_W-1:0] phase_line;
  logic [COUNT_WIDTH-1:0]      chunk_cur;
  logic                        done_cur;
  logic                        err_cur;
  logic                        is_skip;
  chd_pkg::hex_digit_t         hex;

  assign phase_cur = sob_i ? chd_pkg::PH_SIZE : phase_i;
  assign chunk_cur = sob_i ? '0 : chunk_i;
  assign done_cur  = sob_i ? 1'b0 : done_i;
  assign err_cur   = sob_i ? 1'b0 : err_i;
  assign hex       = chd_pkg::hex_decode(byte_i);
  assign is_skip   = (byte_i == chd_pkg::CH_SEMI) || (byte_i == chd_pkg::CH_SPACE) ||
                     (byte_i == chd_pkg::CH_TAB) || (byte_i == chd_pkg::CH_CR);
  assign phase_line = (phase_cur == chd_pkg::PH_EXT) ? chd_pkg::PH_EXT : chd_pkg::PH_SIZE;

  always_comb begin
    phase_o    = phase_cur;
    chunk_o    = chunk_cur;
    done_o     = done_cur;
    err_o      = err_cur;
    out_byte_o = 8'd0;
    status_o   = chd_pkg::ST_FRAME;
    if (err_cur) begin
      status_o = chd_pkg::ST_ERROR;
    end else if (done_cur) begin
      status_o = chd_pkg::ST_IGNORED;
    end else begin
      unique case (phase_cur)
        chd_pkg::PH_DATA: begin
          out_byte_o = byte_i;
          status_o   = chd_pkg::ST_PAYLOAD;
          chunk_o    = chunk_cur - COUNT_WIDTH'(1);
          if (chunk_cur == COUNT_WIDTH'(1)) begin
            phase_o = chd_pkg::PH_DATA_END;
          end
        end
        chd_pkg::PH_DATA_END: begin
          if (byte_i == chd_pkg::CH_LF) begin
            phase_o = chd_pkg::PH_SIZE;
          end else if (byte_i != chd_pkg::CH_CR) begin
            status_o = chd_pkg::ST_ERROR;
            err_o    = 1'b1;
          end
        end
        chd_pkg::PH_TRAILER: begin
          if (byte_i == chd_pkg::CH_LF) begin
            done_o   = 1'b1;
            status_o = chd_pkg::ST_DONE;
          end else if (byte_i != chd_pkg::CH_CR) begin
            phase_o = chd_pkg::PH_TRAILER_LINE;
          end
        end
        chd_pkg::PH_TRAILER_LINE: begin
          if (byte_i == chd_pkg::CH_LF) begin
            phase_o = chd_pkg::PH_TRAILER;
          end
        end
        default: begin
          phase_o = phase_line;
          if (phase_line == chd_pkg::PH_SIZE && hex.is_hex) begin
            if (chunk_cur[COUNT_WIDTH-1:COUNT_WIDTH-8] != 8'd0) begin
              status_o = chd_pkg::ST_ERROR;
              err_o    = 1'b1;
            end else begin
              chunk_o = {chunk_cur[COUNT_WIDTH-5:0], hex.value};
            end
          end else if (byte_i == chd_pkg::CH_LF) begin
            phase_o = (chunk_cur != '0) ? chd_pkg::PH_DATA : chd_pkg::PH_TRAILER;
          end else if (is_skip || phase_line == chd_pkg::PH_EXT) begin
            phase_o = chd_pkg::PH_EXT;
          end else begin
            status_o = chd_pkg::ST_ERROR;
            err_o    = 1'b1;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/http_chunked_body_decoder_core.sv
// Top level of the chunked body decoder: input register, parse state and result register.
//
// Usage: feed the raw chunked body one byte per request on the in_ channel
// (in_byte, in_start_of_body). Raise in_start_of_body with the first byte of
// a new body to clear all parse state before that byte is taken.
// Every input request yields exactly one result request on the out_ channel:
// out_status 0 framing, 1 payload byte in out_byte, 2 body complete,
// 3 error (sticky until the next start flag), 4 byte ignored after the end.
// out_byte is zero unless out_status is 1.
// Each byte is held in the input register; its result is registered when the
// result register loads from the input register.
// Throughput: one byte per cycle while the output is not stalled; the per-byte path
// is one count decrement and compare of COUNT_WIDTH bits feeding the chunk counter.
// Reset: rst_n low at a clock edge empties both registers and returns the
// parser to the size line phase with a zero count.
// Stall: while out_ready is low the result holds; an empty input register still
// takes one more byte, then in_ready drops until the result is taken.
`default_nettype none
module http_chunked_body_decoder_core #(
  parameter int unsigned COUNT_WIDTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   in_byte,
  input  wire logic                         in_start_of_body,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [7:0]                   out_byte,
  output logic      [chd_pkg::STATUS_W-1:0] out_status
);

  logic                           in_valid_r;
  logic [7:0]                     in_byte_r;
  logic                           in_sob_r;
  logic                           out_valid_r;
  logic [7:0]                     out_byte_r;
  logic [chd_pkg::STATUS_W-1:0]   out_status_r;
  logic [chd_pkg::PHASE_W-1:0]    phase_r;
  logic [chd_pkg::PHASE_W-1:0]    phase_nxt;
  logic [COUNT_WIDTH-1:0]         chunk_r;
  logic [COUNT_WIDTH-1:0]         chunk_nxt;
  logic                           done_r;
  logic                           done_nxt;
  logic                           err_r;
  logic                           err_nxt;
  logic [7:0]                     out_byte_nxt;
  logic [chd_pkg::STATUS_W-1:0]   out_status_nxt;
  logic                           out_free;
  logic                           advance;

  assign out_free = !out_valid_r || out_ready;
  assign advance  = in_valid_r && out_free;
  assign in_ready = !in_valid_r || advance;

  chd_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .byte_i    (in_byte_r),
    .sob_i     (in_sob_r),
    .phase_i   (phase_r),
    .chunk_i   (chunk_r),
    .done_i    (done_r),
    .err_i     (err_r),
    .phase_o   (phase_nxt),
    .chunk_o   (chunk_nxt),
    .done_o    (done_nxt),
    .err_o     (err_nxt),
    .out_byte_o(out_byte_nxt),
    .status_o  (out_status_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_byte;
      in_sob_r  <= in_start_of_body;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= chd_pkg::PH_SIZE;
      chunk_r     <= '0;
      done_r      <= 1'b0;
      err_r       <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
      if (advance) begin
        phase_r <= phase_nxt;
        chunk_r <= chunk_nxt;
        done_r  <= done_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r   <= out_byte_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_status = out_status_r;

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r && !(in_valid_r && in_sob_r) |=> err_r)
    else $error("error flag cleared without a start flag");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != chd_pkg::ST_PAYLOAD) |-> out_byte_r == 8'd0)
    else $error("nonzero byte on a non-payload result");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == chd_pkg::PH_DATA |-> chunk_r != '0)
    else $error("payload phase with zero bytes left");

  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && !err_r |-> phase_r == chd_pkg::PH_TRAILER)
    else $error("body complete outside the trailer phase");

endmodule
`default_nettype wire
